FILE: rtl/tts_pkg.sv
// Shared types and constants for the tridiagonal solver.
package tts_pkg;

    localparam int MAX_UNKNOWNS = 64;
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS);

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_C,
        S_MUL_D,
        S_DIV_D,
        S_DIV_C,
        S_BS_RD,
        S_BS_WAIT_RD,
        S_BS_MUL,
        S_BS_OUT,
        S_BS_WAIT
    } t_state;

    typedef enum logic [2:0] {
        D_IDLE,
        D_CHK,
        D_RUN,
        D_FIN,
        D_DONE
    } t_div_state;

endpackage

FILE: rtl/tts_divider.sv
// Serial restoring divider: Q32.32 / Q32.32 -> saturated Q16.16, one quotient bit a cycle.
module tts_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic               o_zero,
    output logic signed [31:0] o_quot
);

    tts_pkg::t_div_state r_st, n_st;

    logic        r_neg, r_nsign, r_nz, r_zero;
    logic [63:0] r_un, r_ud, r_rem;
    logic [31:0] r_low, r_q;
    logic [4:0]  r_cnt;
    logic signed [31:0] r_quot;

    logic [64:0] w_trial;
    logic        w_ge;
    logic        w_load;

    assign w_trial = {r_rem, r_low[31]};
    assign w_ge    = (w_trial >= {1'b0, r_ud});
    assign w_load  = i_start && ((r_st == tts_pkg::D_IDLE) || (r_st == tts_pkg::D_DONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= tts_pkg::D_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            tts_pkg::D_IDLE: if (w_load) n_st = tts_pkg::D_CHK;
            tts_pkg::D_CHK: begin
                if (r_zero || ({16'b0, r_un} >= {r_ud, 16'b0})) n_st = tts_pkg::D_DONE;
                else n_st = tts_pkg::D_RUN;
            end
            tts_pkg::D_RUN:  if (r_cnt == 5'd31) n_st = tts_pkg::D_FIN;
            tts_pkg::D_FIN:  n_st = tts_pkg::D_DONE;
            tts_pkg::D_DONE: n_st = w_load ? tts_pkg::D_CHK : tts_pkg::D_IDLE;
            default:         n_st = tts_pkg::D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_neg   <= i_num[63] ^ i_den[63];
            r_nsign <= i_num[63];
            r_nz    <= (i_num != 64'sd0);
            r_zero  <= (i_den == 64'sd0);
            r_un    <= i_num[63] ? 64'(-i_num) : i_num;
            r_ud    <= i_den[63] ? 64'(-i_den) : i_den;
        end
        case (r_st)
            tts_pkg::D_CHK: begin
                r_rem <= {16'b0, r_un[63:16]};
                r_low <= {r_un[15:0], 16'b0};
                r_q   <= '0;
                r_cnt <= '0;
                if (r_zero)
                    r_quot <= !r_nz ? 32'sd0 : (r_nsign ? tts_pkg::Q_MIN : tts_pkg::Q_MAX);
                else
                    r_quot <= r_neg ? tts_pkg::Q_MIN : tts_pkg::Q_MAX;
            end
            tts_pkg::D_RUN: begin
                r_rem <= w_ge ? 64'(w_trial - {1'b0, r_ud}) : w_trial[63:0];
                r_low <= {r_low[30:0], 1'b0};
                r_q   <= {r_q[30:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            tts_pkg::D_FIN: begin
                if (r_neg)
                    r_quot <= (r_q > 32'h8000_0000) ? tts_pkg::Q_MIN : 32'(-r_q);
                else
                    r_quot <= (r_q > 32'h7FFF_FFFF) ? tts_pkg::Q_MAX : r_q;
            end
            default: ;
        endcase
    end

    assign o_done = (r_st == tts_pkg::D_DONE);
    assign o_zero = r_zero;
    assign o_quot = r_quot;

endmodule

FILE: rtl/tridiagonal_thomas_solver.sv
// Top level of the Thomas-algorithm tridiagonal solver, Q16.16.
// Usage:
//   Input channel (i_valid / o_stall): one beat per matrix row, top row first.
//   i_last_row marks the final row; the row that brings the count to 64 is
//   treated as final regardless. o_stall is high whenever the block is busy.
//   Each row costs two serial divisions by the pivot (one quotient bit a
//   cycle in the shared divider, plus check, finish and done), after
//   multiply and pivot setup (S_MUL_C, S_MUL_D). The last row costs one
//   division. After the last row the solution streams out on the output
//   channel (o_valid / i_stall), highest index first, one beat at a time
//   through read, read wait, shared multiply and output steps, using the
//   registered store read. o_last flags index 0; o_singular reports a
//   zero pivot anywhere in the system.
//   A stalled output beat holds until taken; the solve waits meanwhile.
//   Reset clears the row count, singular flag and sequencer; the c'/d'
//   stores are not cleared (every read follows a write of the same system).
module tridiagonal_thomas_solver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_sub_diag,
    input  logic signed [31:0] i_main_diag,
    input  logic signed [31:0] i_super_diag,
    input  logic signed [31:0] i_rhs,
    input  logic               i_last_row,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_x_value,
    output logic [5:0]         o_x_index,
    output logic               o_singular,
    output logic               o_last
);

    localparam int IW = tts_pkg::IDX_W;

    tts_pkg::t_state r_state, n_state;

    // latched row
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic               r_last;
    logic [IW-1:0]      r_row_cnt;
    logic               r_sing;
    logic               r_div_go;
    logic signed [31:0] r_prev_c, r_prev_d, r_dq;
    logic signed [63:0] r_prod, r_piv;
    // back substitution
    logic [IW-1:0]      r_k;
    logic               r_first;
    logic signed [31:0] r_x;

    // c' and d' stores
    logic signed [31:0] mem_c [tts_pkg::MAX_UNKNOWNS];
    logic signed [31:0] mem_d [tts_pkg::MAX_UNKNOWNS];
    logic signed [31:0] r_rd_c, r_rd_d;

    logic               w_in_acc, w_out_acc;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_mul;
    logic               w_div_start, w_div_done, w_div_zero;
    logic signed [63:0] w_div_num;
    logic signed [31:0] w_quot;
    logic               w_we;
    logic signed [31:0] w_wd_c, w_wd_d;
    logic signed [63:0] w_diff;
    logic signed [31:0] w_xn;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // shared multiplier
    always_comb begin
        w_mul_a = r_a;
        w_mul_b = 32'sd0;
        case (r_state)
            tts_pkg::S_MUL_C:  w_mul_b = (r_row_cnt == '0) ? 32'sd0 : r_prev_c;
            tts_pkg::S_MUL_D:  w_mul_b = (r_row_cnt == '0) ? 32'sd0 : r_prev_d;
            tts_pkg::S_BS_MUL: begin
                w_mul_a = r_rd_c;
                w_mul_b = r_x;
            end
            default: ;
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // divider: d' numerator first (pivot and a*d'[i-1] both registered), then c*2^16
    assign w_div_start = r_div_go ||
                         ((r_state == tts_pkg::S_DIV_D) && w_div_done && !r_last);
    assign w_div_num   = r_div_go
                       ? 64'({{16{r_d[31]}}, r_d, 16'b0} - r_prod)
                       : {{16{r_c[31]}}, r_c, 16'b0};

    tts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_piv),
        .o_done  (w_div_done),
        .o_zero  (w_div_zero),
        .o_quot  (w_quot)
    );

    // store writes
    assign w_we   = w_div_done && (((r_state == tts_pkg::S_DIV_D) && r_last) ||
                                   (r_state == tts_pkg::S_DIV_C));
    assign w_wd_c = (r_state == tts_pkg::S_DIV_C) ? w_quot : 32'sd0;
    assign w_wd_d = (r_state == tts_pkg::S_DIV_C) ? r_dq : w_quot;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_c[r_row_cnt] <= w_wd_c;
            mem_d[r_row_cnt] <= w_wd_d;
        end
        r_rd_c <= mem_c[r_k];
        r_rd_d <= mem_d[r_k];
    end

    // x[k] = d'[k] - floor(c'[k] * x[k+1] / 2^16), saturated
    assign w_diff = $signed({{32{r_rd_d[31]}}, r_rd_d}) - (r_prod >>> 16);
    always_comb begin
        if (r_first)                                 w_xn = r_rd_d;
        else if (w_diff > 64'sh7FFF_FFFF)            w_xn = tts_pkg::Q_MAX;
        else if (w_diff < -64'sh8000_0000)           w_xn = tts_pkg::Q_MIN;
        else                                         w_xn = w_diff[31:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tts_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tts_pkg::S_IDLE:       if (w_in_acc) n_state = tts_pkg::S_MUL_C;
            tts_pkg::S_MUL_C:      n_state = tts_pkg::S_MUL_D;
            tts_pkg::S_MUL_D:      n_state = tts_pkg::S_DIV_D;
            tts_pkg::S_DIV_D: begin
                if (w_div_done) n_state = r_last ? tts_pkg::S_BS_RD : tts_pkg::S_DIV_C;
            end
            tts_pkg::S_DIV_C:      if (w_div_done) n_state = tts_pkg::S_IDLE;
            tts_pkg::S_BS_RD:      n_state = tts_pkg::S_BS_WAIT_RD;
            tts_pkg::S_BS_WAIT_RD: n_state = tts_pkg::S_BS_MUL;
            tts_pkg::S_BS_MUL:     n_state = tts_pkg::S_BS_OUT;
            tts_pkg::S_BS_OUT:     n_state = tts_pkg::S_BS_WAIT;
            tts_pkg::S_BS_WAIT: begin
                if (w_out_acc) n_state = (r_k == '0) ? tts_pkg::S_IDLE : tts_pkg::S_BS_RD;
            end
            default:               n_state = tts_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_sing    <= 1'b0;
            r_div_go  <= 1'b0;
        end else begin
            r_div_go <= (r_state == tts_pkg::S_MUL_D);
            if ((r_state == tts_pkg::S_DIV_D) && w_div_done && w_div_zero)
                r_sing <= 1'b1;
            if ((r_state == tts_pkg::S_DIV_C) && w_div_done)
                r_row_cnt <= r_row_cnt + IW'(1);
            if (w_out_acc && (r_k == '0)) begin
                r_row_cnt <= '0;
                r_sing    <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a    <= i_sub_diag;
            r_b    <= i_main_diag;
            r_c    <= i_super_diag;
            r_d    <= i_rhs;
            r_last <= i_last_row || (r_row_cnt == IW'(tts_pkg::MAX_UNKNOWNS - 1));
        end
        case (r_state)
            tts_pkg::S_MUL_C: r_prod <= w_mul;
            tts_pkg::S_MUL_D: begin
                r_prod <= w_mul;
            end
            tts_pkg::S_DIV_D: begin
                if (w_div_done) begin
                    r_dq    <= w_quot;
                    r_k     <= r_row_cnt;
                    r_first <= 1'b1;
                end
            end
            tts_pkg::S_DIV_C: begin
                if (w_div_done) begin
                    r_prev_c <= w_quot;
                    r_prev_d <= r_dq;
                end
            end
            tts_pkg::S_BS_MUL: r_prod <= w_mul;
            tts_pkg::S_BS_OUT: r_x    <= w_xn;
            tts_pkg::S_BS_WAIT: begin
                if (w_out_acc) begin
                    r_k     <= r_k - IW'(1);
                    r_first <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // The pivot uses r_prod written in S_MUL_C; capture it in S_MUL_D.
    // S_MUL_D overwrites r_prod with a*d'[i-1] at the same edge, and the
    // divider loads pivot and numerator in the next cycle, on r_div_go.
    always_ff @(posedge i_clk) begin
        if (r_state == tts_pkg::S_MUL_D)
            r_piv <= 64'({{16{r_b[31]}}, r_b, 16'b0} - r_prod);
    end

    assign o_stall    = (r_state != tts_pkg::S_IDLE);
    assign o_valid    = (r_state == tts_pkg::S_BS_WAIT);
    assign o_x_value  = r_x;
    assign o_x_index  = 6'(r_k);
    assign o_singular = r_sing;
    assign o_last     = (r_k == '0);

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> (o_x_index == 6'd0))
        else $error("last beat not at index 0");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_last |=> (r_row_cnt == '0) && !r_sing)
        else $error("system state not cleared after run");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("not busy after row accepted");

endmodule
